// File: hw/rtl/ltc_pkg.sv
`timescale 1ns / 1ps

package ltc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W   = 48;
    localparam int STAMP_W = 64;
    localparam int SLOT_W  = 4;
    localparam int TYPE_W  = 2;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 56;

    typedef enum logic [TYPE_W-1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INVAL  = 2'd1,
        REQ_FLUSH  = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } fsm_state_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] hit_idx;
        logic             have_empty;
        logic [IDX_W-1:0] empty_idx;
        logic [IDX_W-1:0] min_idx;
    } scan_res_t;

endpackage

// File: hw/rtl/ltc_scan.sv
`timescale 1ns / 1ps

module ltc_scan (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic                       step,
    input  logic [ltc_pkg::IDX_W-1:0]  idx,
    input  logic                       ent_valid,
    input  logic [ltc_pkg::KEY_W-1:0]  ent_key,
    input  logic [ltc_pkg::STAMP_W-1:0] ent_stamp,
    input  logic [ltc_pkg::KEY_W-1:0]  req_key,
    output ltc_pkg::scan_res_t         res
);
    import ltc_pkg::*;

    scan_res_t          res_reg;
    scan_res_t          res_next;
    logic [STAMP_W-1:0] min_reg;
    logic [STAMP_W-1:0] min_next;
    logic               match;
    logic               older;

    // one key compare and one stamp compare per entry
    assign match = ent_valid && (ent_key == req_key);
    assign older = (idx == '0) || (ent_stamp < min_reg);

    always_comb begin
        res_next = res_reg;
        min_next = min_reg;
        if (start) begin
            res_next.found      = 1'b0;
            res_next.have_empty = 1'b0;
        end else if (step) begin
            if (match && !res_reg.found) begin
                res_next.found   = 1'b1;
                res_next.hit_idx = idx;
            end
            if (!ent_valid && !res_reg.have_empty) begin
                res_next.have_empty = 1'b1;
                res_next.empty_idx  = idx;
            end
            if (older) begin
                min_next         = ent_stamp;
                res_next.min_idx = idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= '0;
            min_reg <= '0;
        end else begin
            res_reg <= res_next;
            min_reg <= min_next;
        end
    end

    assign res = res_reg;

endmodule

// File: hw/rtl/lru_tag_cache.sv
`timescale 1ns / 1ps

// channel   dir  tdata (low bit up)                              tuser
// s_        in   key[47:0], fill_ok[48], zero pad [55:49]         req_type[1:0]
// m_        out  hit[0], present[1], slot[5:2], victim_valid[6],  -
//                victim_key[54:7], zero pad [55]
//
// a lookup or invalidate walks all ENTRIES slots, one per cycle, through one
// key compare and one stamp compare
// flush and unused types skip the scan
// reset clears the valid bits and the use counter
// a held result beat stalls the final commit, and no new beat is taken meanwhile

module lru_tag_cache (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ltc_pkg::S_DATA_W-1:0]  s_tdata,  // key, fill_ok
    input  logic [ltc_pkg::TYPE_W-1:0]    s_tuser,  // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ltc_pkg::M_DATA_W-1:0]  m_tdata   // hit, present, slot, victim_valid, victim_key
);
    import ltc_pkg::*;

    fsm_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [TYPE_W-1:0]  type_reg;
    logic [KEY_W-1:0]   key_reg;
    logic               fill_reg;
    logic [STAMP_W-1:0] cnt_reg;

    logic               valid_reg [ENTRIES];
    logic [KEY_W-1:0]   key_mem   [ENTRIES];
    logic [STAMP_W-1:0] stamp_mem [ENTRIES];

    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    scan_res_t        res;
    logic             accept;
    logic             out_free;
    logic             commit;
    logic [IDX_W-1:0] target;

    logic             wr_key_en;
    logic             wr_stamp_en;
    logic             wr_valid_en;
    logic             wr_valid_val;
    logic             flush_all;
    logic [IDX_W-1:0] wr_idx;

    logic               r_hit;
    logic               r_present;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_vvalid;
    logic [KEY_W-1:0]   r_vkey;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == ST_DONE) && out_free;
    assign target   = res.have_empty ? res.empty_idx : res.min_idx;

    ltc_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .step      (state_reg == ST_SCAN),
        .idx       (idx_reg),
        .ent_valid (valid_reg[idx_reg]),
        .ent_key   (key_mem[idx_reg]),
        .ent_stamp (stamp_mem[idx_reg]),
        .req_key   (key_reg),
        .res       (res)
    );

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wr_key_en     = 1'b0;
        wr_stamp_en   = 1'b0;
        wr_valid_en   = 1'b0;
        wr_valid_val  = 1'b0;
        flush_all     = 1'b0;
        wr_idx        = res.hit_idx;
        r_hit         = 1'b0;
        r_present     = 1'b0;
        r_slot        = '0;
        r_vvalid      = 1'b0;
        r_vkey        = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (type_reg)
            REQ_LOOKUP: begin
                if (res.found) begin
                    r_hit       = 1'b1;
                    r_present   = 1'b1;
                    r_slot      = SLOT_W'(res.hit_idx);
                    wr_stamp_en = 1'b1;
                end else begin
                    wr_idx       = target;
                    r_slot       = SLOT_W'(target);
                    r_present    = fill_reg;
                    r_vvalid     = !res.have_empty;
                    r_vkey       = res.have_empty ? '0 : key_mem[target];
                    wr_valid_en  = 1'b1;
                    wr_valid_val = fill_reg;
                    wr_key_en    = fill_reg;
                    wr_stamp_en  = fill_reg;
                end
            end
            REQ_INVAL: begin
                if (res.found) begin
                    r_present    = 1'b1;
                    r_slot       = SLOT_W'(res.hit_idx);
                    wr_valid_en  = 1'b1;
                    wr_valid_val = 1'b0;
                end
            end
            REQ_FLUSH: begin
                flush_all = 1'b1;
            end
            default: begin
            end
        endcase

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_next = '0;
                    if (s_tuser == REQ_LOOKUP || s_tuser == REQ_INVAL) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (idx_reg == IDX_W'(ENTRIES - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({r_vkey, r_vvalid, r_slot, r_present, r_hit});
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (!commit) begin
            wr_key_en   = 1'b0;
            wr_stamp_en = 1'b0;
            wr_valid_en = 1'b0;
            flush_all   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (accept && s_tuser == REQ_LOOKUP) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (flush_all) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    valid_reg[i] <= 1'b0;
                end
            end else if (wr_valid_en) begin
                valid_reg[wr_idx] <= wr_valid_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
        if (accept) begin
            type_reg <= s_tuser;
            key_reg  <= s_tdata[KEY_W-1:0];
            fill_reg <= s_tdata[KEY_W];
        end
        if (wr_key_en) begin
            key_mem[wr_idx] <= key_reg;
        end
        if (wr_stamp_en) begin
            stamp_mem[wr_idx] <= cnt_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
